[src/swa_pkg.sv]
// ----------------------------------------------------------------------------
// swa_pkg
// shared widths, register map and controller/datapath interface types of the
// sliding window average core
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_W    = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = SAMPLE_W + PTR_W + 1;
    localparam int MAG_W       = SUM_W - 1;
    localparam int DCNT_W      = $clog2(MAG_W);
    localparam int WIN_FIELD_W = 7;
    localparam int WIN_RESET   = 10;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(0);

    typedef struct packed {
        logic accept;
        logic evict;
        logic update;
        logic div_load;
        logic div_step;
        logic zero;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] window;
        logic             div_last;
        logic             out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

[src/swa_ram.sv]
// ----------------------------------------------------------------------------
// swa_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/swa_ctrl.sv]
// ----------------------------------------------------------------------------
// swa_ctrl
// sequencer of the sliding window average core: accept, history update,
// divider load, bit-serial divide and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module swa_ctrl
    import swa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_stat.window == '0) begin
                        o_cmd.zero = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        o_cmd.accept = 1'b1;
                        o_cmd.evict  = (i_stat.fill >= i_stat.window);
                        n_state      = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[src/swa_dp.sv]
// ----------------------------------------------------------------------------
// swa_dp
// datapath of the sliding window average core: window register, sample ring,
// running sum, restoring divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module swa_dp
    import swa_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_stat                    o_stat,
    input  wire logic                   i_cfg_we,
    input  wire logic [WIN_FIELD_W-1:0] i_cfg_data,
    input  wire logic [SAMPLE_W-1:0]    i_sample,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [SAMPLE_W-1:0]    o_average
);

    logic [CNT_W-1:0]    r_window;
    logic [PTR_W-1:0]    r_wp;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_evict;
    logic                r_neg;
    logic [CNT_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_dvd;
    logic [DCNT_W-1:0]   r_cnt;
    logic [SAMPLE_W-1:0] r_avg;
    logic                r_out_valid;

    logic [SAMPLE_W-1:0] ring_rdata;
    logic [PTR_W-1:0]    oldest;
    logic [SUM_W-1:0]    old_ext;
    logic [SUM_W-1:0]    new_ext;
    logic [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]    sum_abs;
    logic [CNT_W:0]      trial;
    logic                q_bit;
    logic [CNT_W:0]      rem_sub;
    logic [MAG_W-1:0]    quo_signed;
    logic [CNT_W-1:0]    win_sat;
    logic                out_free;

    // oldest held sample sits fill slots behind the write pointer
    assign oldest  = r_wp - r_fill[PTR_W-1:0];

    swa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_re    (i_cmd.accept),
        .i_raddr (oldest),
        .o_rdata (ring_rdata)
    );

    assign old_ext = r_evict ? {{(SUM_W-SAMPLE_W){ring_rdata[SAMPLE_W-1]}}, ring_rdata}
                             : '0;
    assign new_ext = {{(SUM_W-SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
    assign n_sum   = r_sum - old_ext + new_ext;
    assign sum_abs = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    // restoring divide step, one quotient bit per cycle
    assign trial   = {r_rem, r_dvd[MAG_W-1]};
    assign q_bit   = (trial >= {1'b0, r_fill});
    assign rem_sub = trial - {1'b0, r_fill};

    assign quo_signed = r_neg ? (~r_dvd + MAG_W'(1)) : r_dvd;

    assign win_sat = (32'(i_cfg_data) > 32'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW)
                                                         : CNT_W'(i_cfg_data);

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= CNT_W'(WIN_RESET);
            r_wp        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= win_sat;
                r_wp     <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
            end else if (i_cmd.update) begin
                r_wp  <= r_wp + PTR_W'(1);
                r_sum <= n_sum;
                if (!r_evict) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_evict  <= i_cmd.evict;
        end
        if (i_cmd.zero) begin
            r_neg <= 1'b0;
            r_dvd <= '0;
        end else if (i_cmd.div_load) begin
            r_neg <= r_sum[SUM_W-1];
            r_dvd <= sum_abs[MAG_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? rem_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            r_dvd <= {r_dvd[MAG_W-2:0], q_bit};
            r_cnt <= r_cnt + DCNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_avg <= quo_signed[SAMPLE_W-1:0];
        end
    end

    assign o_stat.fill     = r_fill;
    assign o_stat.window   = r_window;
    assign o_stat.div_last = (r_cnt == DCNT_W'(MAG_W - 1));
    assign o_stat.out_free = out_free;

    assign o_valid   = r_out_valid;
    assign o_average = r_avg;

endmodule

`default_nettype wire

[src/sliding_window_average_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_average_core
// simple moving average of signed samples over a configurable window
// ----------------------------------------------------------------------------
// Each accepted sample returns the mean of the last window_size samples,
// truncated toward zero; until the window has filled, the mean covers the
// samples received since the last window_size write, and a window of 0 gives
// 0. The window register sits at APB byte address 0 and is saturated to 64;
// writing it clears the history. One sample is in flight at a time: with a
// non-zero window an item goes through accept, sum update, divider load,
// 22 bit-serial restoring divide steps at one quotient bit per cycle and
// result hand-off before the next acceptance; with a zero window it goes
// straight from acceptance to hand-off. A finished result waits in the
// output register and holds the sequencer only when the next result is
// ready before it has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_average_core
    import swa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [SAMPLE_W-1:0]   i_sample,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [SAMPLE_W-1:0]   o_average,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     reg_hit;
    logic     cfg_we;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_WINDOW);
    assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? APB_DATA_W'(stat.window) : '0;

    swa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    swa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (pwdata[WIN_FIELD_W-1:0]),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_average  (o_average)
    );

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.fill <= stat.window)
        else $error("fill count above window size");

    a_window_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.window <= CNT_W'(MAX_WINDOW))
        else $error("window size above maximum");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_valid)
        else $error("loaded result not presented");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sliding window average core
// ----------------------------------------------------------------------------
// Drives signed samples through the valid/stall request channel and predicts
// each average from a local copy of the sample ring, fill count and running
// sum. The window register is rewritten over the APB port between phases,
// including zero, one, the maximum, saturating values and writes to an
// unmapped register. Both sides idle and stall at random, and the receiver
// once holds off long enough for the core to back up its input.
// ----------------------------------------------------------------------------

module testbench;
    import swa_pkg::*;

    typedef enum int {
        MIX_UNIFORM,
        MIX_EXTREME,
        MIX_HIGH,
        MIX_LOW,
        MIX_SMALL
    } t_mix;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(1);
    localparam int ITEM_TARGET    = 1120;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam logic [SAMPLE_W-1:0] FIRST_SAMPLES [12] = '{
        16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0001,
        16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFD, 16'h0007
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [SAMPLE_W-1:0]   o_average;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sliding_window_average_core u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_average (o_average),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // local copy of the averaging state
    logic        [WIN_FIELD_W-1:0] window_cfg;
    logic signed [SAMPLE_W-1:0]    hist_ring [MAX_WINDOW];
    logic        [PTR_W-1:0]       hist_wptr;
    logic        [CNT_W-1:0]       hist_fill;
    logic signed [SUM_W-1:0]       hist_sum;

    logic [SAMPLE_W-1:0] sample_q [$];
    logic [SAMPLE_W-1:0] average_q [$];

    int  items_pushed = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  quiet_cycles = 0;
    bit  snd_idle_on = 1'b1;
    bit  rcv_idle_on = 1'b1;
    bit  hold_done = 1'b0;

    function automatic void set_window(input logic [APB_DATA_W-1:0] value);
        logic [WIN_FIELD_W-1:0] w;
        w = value[WIN_FIELD_W-1:0];
        if (w > MAX_WINDOW) begin
            w = WIN_FIELD_W'(MAX_WINDOW);
        end
        window_cfg = w;
        hist_wptr  = '0;
        hist_fill  = '0;
        hist_sum   = '0;
    endfunction

    function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] smp);
        int quot;
        if (window_cfg == 0) begin
            return '0;
        end
        if (hist_fill >= window_cfg) begin
            hist_sum  = hist_sum - hist_ring[PTR_W'(hist_wptr - hist_fill)];
            hist_fill = hist_fill - 1'b1;
        end
        hist_ring[hist_wptr] = $signed(smp);
        hist_wptr = hist_wptr + 1'b1;
        hist_sum  = hist_sum + $signed(smp);
        hist_fill = hist_fill + 1'b1;
        quot = int'(hist_sum) / int'(hist_fill);
        return SAMPLE_W'(quot);
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(input t_mix mix);
        case (mix)
            MIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            MIX_HIGH:    return 16'h7FFF - SAMPLE_W'($urandom_range(0, 3));
            MIX_LOW:     return 16'h8000 + SAMPLE_W'($urandom_range(0, 3));
            MIX_SMALL:   return SAMPLE_W'($urandom_range(0, 16)) - 16'd8;
            default:     return SAMPLE_W'($urandom);
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                average_q = {average_q, next_average(i_sample)};
                gap_left = snd_idle_on ? $urandom_range(0, 5) : 0;
            end
            if (i_valid && o_stall) begin
                // hold the stalled request
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                i_valid  <= 1'b1;
                i_sample <= sample_q[0];
                sample_q.delete(0);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        logic [SAMPLE_W-1:0] want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_stall && stall_left > 0) begin
                stall_left--;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (average_q.size() == 0) begin
                    $error("average: result with no expectation, got %0d",
                           $signed(o_average));
                    mismatches++;
                end else begin
                    want = average_q[0];
                    average_q.delete(0);
                    if (o_average !== want) begin
                        $error("average mismatch: expected %0d, got %0d",
                               $signed(want), $signed(o_average));
                        mismatches++;
                    end
                end
                stall_left = rcv_idle_on ? $urandom_range(0, 5) : 0;
                if (!hold_done && results_seen >= HOLD_AFTER && sample_q.size() > 4) begin
                    stall_left = HOLD_CYCLES;
                    hold_done  = 1'b1;
                end
            end
            i_stall <= (stall_left > 0);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input logic [REG_IDX_W-1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_window_readback();
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, REG_WINDOW, '0, rdata);
        if (rdata !== APB_DATA_W'(window_cfg)) begin
            $error("window_size readback mismatch: expected %0d, got %0d",
                   window_cfg, rdata);
            mismatches++;
        end
    endtask

    task automatic reg_write(input logic [REG_IDX_W-1:0] idx,
                             input logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] unused_rd;
        apb_access(1'b1, idx, value, unused_rd);
        if (idx == REG_WINDOW) begin
            set_window(value);
        end
        check_window_readback();
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        sample_q = {sample_q, smp};
        items_pushed++;
    endtask

    task automatic drain();
        while (results_seen != items_pushed) @(posedge i_clk);
    endtask

    initial begin
        logic [APB_DATA_W-1:0] wdata;
        int                    w;
        int                    n;
        t_mix                  mix;

        set_window(APB_DATA_W'(WIN_RESET));
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window: fill, then evict past the window
        check_window_readback();
        foreach (FIRST_SAMPLES[k]) send_sample(FIRST_SAMPLES[k]);
        drain();

        // unmapped register keeps the history
        reg_write(REG_UNUSED, 32'h0000_0003);
        send_sample(16'd100);
        send_sample(-16'sd100);
        drain();

        // zero window
        reg_write(REG_WINDOW, 32'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();

        // saturates to the maximum window
        reg_write(REG_WINDOW, 32'd100);
        send_sample(16'h8000);
        drain();

        reg_write(REG_WINDOW, 32'd1);
        send_sample(16'd5);
        send_sample(-16'sd5);
        send_sample(16'h7FFF);
        drain();

        while (items_pushed < ITEM_TARGET) begin
            snd_idle_on = ($urandom_range(0, 3) != 0);
            rcv_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) begin
                reg_write(REG_UNUSED, $urandom);
            end else begin
                case ($urandom_range(0, 7))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = 2;
                    3:       w = MAX_WINDOW;
                    4:       w = $urandom_range(MAX_WINDOW + 1, 127);
                    default: w = $urandom_range(3, MAX_WINDOW - 1);
                endcase
                wdata = APB_DATA_W'(w);
                if ($urandom_range(0, 3) == 0) begin
                    wdata = wdata | ($urandom & 32'hFFFF_FF80);
                end
                reg_write(REG_WINDOW, wdata);
            end
            n = (window_cfg == 0) ? $urandom_range(5, 20)
                                  : $urandom_range(5, 2 * window_cfg + 12);
            mix = t_mix'($urandom_range(0, 4));
            repeat (n) send_sample(draw_sample(mix));
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (average_q.size() != 0) begin
            $error("average: %0d expected results never arrived", average_q.size());
        end
        if (mismatches == 0 && average_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/swa_pkg.sv
src/swa_ram.sv
src/swa_ctrl.sv
src/swa_dp.sv
src/sliding_window_average_core.sv
dv/testbench.sv
